// ----- src/pgbw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgbw_pkg
// Shared constants, opcodes, prime table and controller/datapath structs for
// the prime grid byte walk unit.
// ----------------------------------------------------------------------------
package pgbw_pkg;

  localparam int GRID_SIDE         = 16;
  localparam int TILE_COUNT        = GRID_SIDE * GRID_SIDE;
  localparam int COORD_W           = $clog2(GRID_SIDE);
  localparam int TILE_AW           = 2 * COORD_W;
  localparam int PRIME_TABLE_DEPTH = 1024;
  localparam int IDX_W             = $clog2(PRIME_TABLE_DEPTH);
  localparam int PRIME_W           = 16;
  localparam int COLOR_COUNT       = 4;
  localparam int COLOR_W           = $clog2(COLOR_COUNT);
  localparam int TILE_W            = IDX_W + COLOR_W;
  localparam int CFG_W             = 11;
  localparam int SUM_W             = CFG_W;
  localparam int DIV_STEPS         = SUM_W;
  localparam int CNT_W             = $clog2(DIV_STEPS);
  localparam int STEPS_PER_BYTE    = 4;
  localparam int STEP_W            = $clog2(STEPS_PER_BYTE);
  localparam int OP_W              = 2;
  localparam int BYTE_W            = 8;
  localparam int DIR_W             = 2;
  localparam int SIEVE_LIMIT       = 8192;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(PRIME_TABLE_DEPTH);
  localparam logic [SUM_W-1:0] MOD_MAX   = SUM_W'(PRIME_TABLE_DEPTH);
  localparam logic [SUM_W-1:0] MOD_MIN   = SUM_W'(1);

  localparam logic [OP_W-1:0] OP_ABSORB = 2'd0;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

  typedef logic [PRIME_W-1:0] prime_table_t [PRIME_TABLE_DEPTH];

  typedef struct packed {
    logic accept;
    logic rd;
    logic rd_tile;
    logic lookup;
    logic reduce;
    logic div_step;
    logic write;
    logic move;
    logic out_load;
  } pgbw_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic [OP_W-1:0] op;
    logic            fast_ok;
    logic            out_free;
  } pgbw_sts_t;

  function automatic prime_table_t build_prime_table();
    bit [SIEVE_LIMIT-1:0] composite;
    prime_table_t         tbl;
    int                   found;
    composite = '0;
    tbl       = '{default: '0};
    found     = 0;
    for (int i = 2; i * i < SIEVE_LIMIT; i++) begin
      if (!composite[i]) begin
        for (int j = i * i; j < SIEVE_LIMIT; j += i) begin
          composite[j] = 1'b1;
        end
      end
    end
    for (int i = 2; i < SIEVE_LIMIT; i++) begin
      if (!composite[i] && found < PRIME_TABLE_DEPTH) begin
        tbl[found] = PRIME_W'(i);
        found++;
      end
    end
    return tbl;
  endfunction

  localparam prime_table_t PRIME_TABLE = build_prime_table();

endpackage
`default_nettype wire

// ----- src/pgbw_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgbw_item_if / pgbw_result_if
// Valid/ready channels for requests and results of the grid walk unit.
// ----------------------------------------------------------------------------
interface pgbw_item_if import pgbw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [BYTE_W-1:0]  data_byte;
  logic [COORD_W-1:0] read_col;
  logic [COORD_W-1:0] read_row;

  modport source (output valid, output opcode, output data_byte, output read_col,
                  output read_row, input ready);
  modport sink   (input valid, input opcode, input data_byte, input read_col,
                  input read_row, output ready);
endinterface

interface pgbw_result_if import pgbw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] cursor_col;
  logic [COORD_W-1:0] cursor_row;
  logic [PRIME_W-1:0] tile_prime;
  logic [COLOR_W-1:0] tile_color;

  modport source (output valid, output cursor_col, output cursor_row,
                  output tile_prime, output tile_color, input ready);
  modport sink   (input valid, input cursor_col, input cursor_row,
                  input tile_prime, input tile_color, output ready);
endinterface
`default_nettype wire

// ----- src/pgbw_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgbw_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pgbw_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- src/pgbw_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgbw_datapath
// Tile store, prime lookup, index reduction, cursor walk and result register.
// ----------------------------------------------------------------------------
module pgbw_datapath import pgbw_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  input  wire logic [OP_W-1:0]    opcode,
  input  wire logic [BYTE_W-1:0]  data_byte,
  input  wire logic [COORD_W-1:0] read_col,
  input  wire logic [COORD_W-1:0] read_row,
  input  wire pgbw_cmd_t          cmd,
  output      pgbw_sts_t          sts,
  pgbw_result_if.source           result
);

  logic [OP_W-1:0]    op;
  logic [BYTE_W-1:0]  byte_sh;
  logic [COORD_W-1:0] rd_col;
  logic [COORD_W-1:0] rd_row;
  logic [COORD_W-1:0] cur_col;
  logic [COORD_W-1:0] cur_row;
  logic [CFG_W-1:0]   nprimes;
  logic [TILE_COUNT-1:0] tile_valid;
  logic               valid_q;
  logic [TILE_AW-1:0] raddr;
  logic [TILE_AW-1:0] waddr;
  logic [TILE_W-1:0]  ram_q;
  logic [TILE_W-1:0]  ram_wdata;
  logic [TILE_W-1:0]  tile_now;
  logic [COLOR_W-1:0] tile_clr;
  logic [PRIME_W-1:0] prime_q;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   red;
  logic [SUM_W-1:0]   num;
  logic [SUM_W-1:0]   modulus;
  logic [SUM_W-1:0]   diff;
  logic [SUM_W-1:0]   rem_shift;
  logic [DIR_W-1:0]   dir;
  logic [COORD_W-1:0] hop;
  logic [COORD_W-1:0] fwd;
  logic               out_valid;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic [PRIME_W-1:0] out_prime;
  logic [COLOR_W-1:0] out_color;

  pgbw_ram #(
    .WIDTH (TILE_W),
    .DEPTH (TILE_COUNT)
  ) u_tile_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_comb begin
    if (nprimes == '0) begin
      modulus = MOD_MIN;
    end else if (nprimes > MOD_MAX) begin
      modulus = MOD_MAX;
    end else begin
      modulus = nprimes;
    end
  end

  assign dir       = (op == OP_ABSORB) ? byte_sh[DIR_W-1:0] : DIR_UP;
  assign tile_now  = valid_q ? ram_q : '0;
  assign diff      = sum - modulus;
  assign rem_shift = {red[SUM_W-2:0], num[SUM_W-1]};
  assign raddr     = cmd.rd_tile ? {rd_col, rd_row} : {cur_col, cur_row};
  assign waddr     = {cur_col, cur_row};
  assign ram_wdata = {red[IDX_W-1:0], COLOR_W'(tile_clr + 1'b1)};
  assign hop       = prime_q[COORD_W-1:0];
  assign fwd       = hop + 1'b1;

  assign sts.in_op    = opcode;
  assign sts.op       = op;
  assign sts.fast_ok  = (sum < modulus) || (diff < modulus);
  assign sts.out_free = !out_valid || result.ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      nprimes    <= CFG_RESET;
      tile_valid <= '0;
      cur_col    <= '0;
      cur_row    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        nprimes <= cfg_wdata;
      end
      if (cmd.accept && opcode == OP_CLEAR) begin
        tile_valid <= '0;
        cur_col    <= '0;
        cur_row    <= '0;
      end
      if (cmd.write) begin
        tile_valid[waddr] <= 1'b1;
        if (cmd.move) begin
          case (dir)
            DIR_UP:    cur_row <= cur_row - hop;
            DIR_RIGHT: cur_col <= cur_col + fwd;
            DIR_LEFT:  cur_col <= cur_col - hop;
            DIR_DOWN:  cur_row <= cur_row + fwd;
            default:   cur_row <= cur_row;
          endcase
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op      <= opcode;
      byte_sh <= data_byte;
      rd_col  <= read_col;
      rd_row  <= read_row;
    end
    if (cmd.write) begin
      byte_sh <= byte_sh >> DIR_W;
    end
    if (cmd.rd) begin
      valid_q <= tile_valid[raddr];
    end
    if (cmd.lookup) begin
      tile_clr <= tile_now[COLOR_W-1:0];
      prime_q  <= PRIME_TABLE[tile_now[TILE_W-1:COLOR_W]];
      sum      <= SUM_W'(tile_now[TILE_W-1:COLOR_W]) + SUM_W'(dir) + 1'b1;
    end
    if (cmd.reduce) begin
      if (sum < modulus) begin
        red <= sum;
      end else if (diff < modulus) begin
        red <= diff;
      end else begin
        red <= '0;
        num <= sum;
      end
    end
    // restoring remainder, one quotient bit per cycle
    if (cmd.div_step) begin
      red <= (rem_shift >= modulus) ? rem_shift - modulus : rem_shift;
      num <= num << 1;
    end
    if (cmd.out_load) begin
      out_col   <= cur_col;
      out_row   <= cur_row;
      out_prime <= prime_q;
      out_color <= tile_clr;
    end
  end

  assign result.valid      = out_valid;
  assign result.cursor_col = out_col;
  assign result.cursor_row = out_row;
  assign result.tile_prime = out_prime;
  assign result.tile_color = out_color;

endmodule
`default_nettype wire

// ----- src/pgbw_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgbw_ctrl
// Sequencer for request intake, walk steps, index reduction and result load.
// ----------------------------------------------------------------------------
module pgbw_ctrl import pgbw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output      logic      item_ready,
  input  wire pgbw_sts_t sts,
  output      pgbw_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_LK   = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              fin;
  logic              fin_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cnt_next   = cnt;
    fin_next   = fin;
    cmd        = '0;
    item_ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          step_next  = '0;
          fin_next   = (sts.in_op == OP_READ) || (sts.in_op == OP_CLEAR);
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd      = 1'b1;
        cmd.rd_tile = fin && (sts.op == OP_READ);
        state_next  = S_LK;
      end
      S_LK: begin
        cmd.lookup = 1'b1;
        state_next = fin ? S_FIN : S_MOD;
      end
      S_MOD: begin
        cmd.reduce = 1'b1;
        cnt_next   = '0;
        state_next = sts.fast_ok ? S_WB : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        cmd.write = 1'b1;
        cmd.move  = (sts.op == OP_ABSORB);
        if (sts.op == OP_ABSORB && step != STEP_W'(STEPS_PER_BYTE - 1)) begin
          step_next = step + 1'b1;
        end else begin
          fin_next = 1'b1;
        end
        state_next = S_RD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      cnt   <= '0;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      cnt   <= cnt_next;
      fin   <= fin_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/prime_grid_byte_walk_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prime_grid_byte_walk_unit
// Absorb stage of a grid walk hash: tile prime indices and colors on a
// square grid, updated by a cursor that walks by the tile primes.
// ----------------------------------------------------------------------------
// read and clear: tile read, prime lookup, result load. finish: one tile
// update without a cursor move, then read, lookup, load. absorb: 4 walk
// steps, then read, lookup, load. An index reduction needing more than one
// subtract uses the bit-serial remainder unit; one request in flight at a time
// reset: cursor at (0,0), all tiles cleared at once through per-tile valid
// bits, prime count at 1024; no clearing pass
module prime_grid_byte_walk_unit import pgbw_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  pgbw_item_if.sink             item,
  pgbw_result_if.source         result
);

  pgbw_cmd_t cmd;
  pgbw_sts_t sts;
  logic      item_ready;

  assign item.ready = item_ready;

  pgbw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pgbw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .opcode    (item.opcode),
    .data_byte (item.data_byte),
    .read_col  (item.read_col),
    .read_row  (item.read_row),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

endmodule
`default_nettype wire
